// ----- design/pit_ch_pkg.sv -----
// Package for the interval timer channel 0 rate generator.
// Holds the bus cycle codes, access modes and the item and result types.
// No dependencies.
package pit_ch_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ACC_LATCH = 2'd0,
		ACC_LOW   = 2'd1,
		ACC_HIGH  = 2'd2,
		ACC_BOTH  = 2'd3
	} access_t;

	localparam logic [1:0] PORT_CH0  = 2'd0;
	localparam logic [1:0] PORT_CTRL = 2'd3;
	localparam logic [1:0] SEL_CH0   = 2'd0;

	typedef struct packed {
		logic [7:0] write_byte;
		logic [1:0] port;
		opcode_t    opcode;
	} item_t;

	typedef struct packed {
		logic       out_level;
		logic [7:0] read_data;
	} result_t;

endpackage

// ----- design/pit_ch_core.sv -----
// Counter, reload and latch state of the timer channel with its update logic.
// Computes the result of one bus cycle and commits the new state when fired.
// Depends on pit_ch_pkg.
module pit_ch_core
	import pit_ch_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	output result_t result
);

	logic [15:0] reload_q, count_q, latched_q;
	logic        latch_held_q, write_high_q, read_high_q, counting_q, load_pending_q, out_q;
	access_t     mode_q;

	logic [15:0] reload_d, count_d, latched_d;
	logic        latch_held_d, write_high_d, read_high_d, counting_d, load_pending_d, out_d;
	access_t     mode_d;
	logic [7:0]  rdata;
	logic [15:0] view;
	logic        load_done;

	always_comb begin
		reload_d       = reload_q;
		count_d        = count_q;
		latched_d      = latched_q;
		latch_held_d   = latch_held_q;
		write_high_d   = write_high_q;
		read_high_d    = read_high_q;
		counting_d     = counting_q;
		load_pending_d = load_pending_q;
		out_d          = out_q;
		mode_d         = mode_q;
		rdata          = 8'd0;
		load_done      = 1'b0;
		view           = latch_held_q ? latched_q : count_q;

		case (item.opcode)
			OP_TICK: begin
				if (load_pending_q) begin
					count_d        = reload_q;
					load_pending_d = 1'b0;
					counting_d     = 1'b1;
				end else if (counting_q) begin
					if (count_q == 16'd1) begin
						count_d = reload_q;
						out_d   = 1'b1;
					end else begin
						count_d = count_q - 16'd1;
						if (count_q == 16'd2) begin
							out_d = 1'b0;
						end
					end
				end
			end
			OP_WRITE: begin
				if (item.port == PORT_CTRL) begin
					if (item.write_byte[7:6] == SEL_CH0) begin
						if (access_t'(item.write_byte[5:4]) == ACC_LATCH) begin
							if (!latch_held_q) begin
								latched_d    = count_q;
								latch_held_d = 1'b1;
							end
						end else begin
							mode_d         = access_t'(item.write_byte[5:4]);
							write_high_d   = 1'b0;
							read_high_d    = 1'b0;
							latch_held_d   = 1'b0;
							counting_d     = 1'b0;
							load_pending_d = 1'b0;
							out_d          = 1'b1;
						end
					end
				end else if (item.port == PORT_CH0) begin
					case (mode_q)
						ACC_LOW: begin
							reload_d  = {8'd0, item.write_byte};
							load_done = 1'b1;
						end
						ACC_HIGH: begin
							reload_d  = {item.write_byte, 8'd0};
							load_done = 1'b1;
						end
						ACC_BOTH: begin
							if (!write_high_q) begin
								reload_d     = {reload_q[15:8], item.write_byte};
								write_high_d = 1'b1;
							end else begin
								reload_d     = {item.write_byte, reload_q[7:0]};
								write_high_d = 1'b0;
								load_done    = 1'b1;
							end
						end
						default: begin
						end
					endcase
					if (load_done && !counting_q) begin
						load_pending_d = 1'b1;
					end
				end
			end
			OP_READ: begin
				if (item.port == PORT_CH0) begin
					case (mode_q)
						ACC_LOW: begin
							latch_held_d = 1'b0;
							rdata        = view[7:0];
						end
						ACC_HIGH: begin
							latch_held_d = 1'b0;
							rdata        = view[15:8];
						end
						ACC_BOTH: begin
							if (!read_high_q) begin
								read_high_d = 1'b1;
								rdata       = view[7:0];
							end else begin
								read_high_d  = 1'b0;
								latch_held_d = 1'b0;
								rdata        = view[15:8];
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase

		result.read_data = rdata;
		result.out_level = out_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q       <= 16'd0;
			count_q        <= 16'd0;
			latched_q      <= 16'd0;
			latch_held_q   <= 1'b0;
			write_high_q   <= 1'b0;
			read_high_q    <= 1'b0;
			counting_q     <= 1'b0;
			load_pending_q <= 1'b0;
			out_q          <= 1'b1;
			mode_q         <= ACC_BOTH;
		end else if (fire) begin
			reload_q       <= reload_d;
			count_q        <= count_d;
			latched_q      <= latched_d;
			latch_held_q   <= latch_held_d;
			write_high_q   <= write_high_d;
			read_high_q    <= read_high_d;
			counting_q     <= counting_d;
			load_pending_q <= load_pending_d;
			out_q          <= out_d;
			mode_q         <= mode_d;
		end
	end

endmodule

// ----- design/pit_rate_generator_channel_top.sv -----
// Top level of the interval timer channel 0 in rate generator mode.
// Holds the input and result registers and the stream handshakes.
// Depends on pit_ch_pkg and pit_ch_core.

// Each transaction on the slave side is one bus cycle (clock tick, port write or port read) and
// yields exactly one transaction on the master side carrying the read byte and the OUT level.
// A transaction is held in the input register, evaluated against the channel state and written
// to the result register, and one transaction is taken in every cycle while the master side
// keeps tready high; the counter state is committed in the same cycle as the result is
// registered, which sets that rate.
module pit_rate_generator_channel_top
	import pit_ch_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // opcode[1:0], port[3:2], write_byte[11:4], zero[15:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // read_data[7:0], out_level[8], zero[15:9]
);

	logic    valid_s1, valid_s2;
	item_t   item_s1;
	result_t result_s2;
	result_t result;
	logic    adv;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_t'({s_tdata[11:4], s_tdata[3:2], s_tdata[1:0]});
		end
		if (adv) begin
			result_s2 <= result;
		end
	end

	pit_ch_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.item   (item_s1),
		.result (result)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, result_s2.out_level, result_s2.read_data};

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("input register dropped a transaction");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input register empty but not ready");

	a_no_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !(item_s1.opcode == OP_READ && item_s1.port == PORT_CH0) |=> m_tdata[7:0] == 8'd0)
		else $error("read data returned for a transaction that is not a channel 0 read");

endmodule
